// File: rtl/owlog_pkg.sv
// Shared types and constants for the overwrite-oldest byte log ring.
package owlog_pkg;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 7;
    localparam int LEVEL_W = 14;

    typedef enum logic [0:0] {
        CMD_WRITE = 1'b0,
        CMD_READ  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_BYTE = 2'd0,
        STATUS_EOF  = 2'd1,
        STATUS_ZERO = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STATUS,
        ST_READ
    } state_t;

    typedef struct packed {
        cmd_t               command;
        logic [BYTE_W-1:0]  data_byte;
        logic               end_of_message;
        logic [LEN_W-1:0]   read_length;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        status_t            status;
        logic               last;
        logic [LEVEL_W-1:0] level;
    } out_item_t;

endpackage

// File: rtl/overwrite_oldest_log_ring_top.sv
// Overwrite-oldest byte log ring: a circular byte log held in one synchronous memory.
//
// Requests arrive on the s_ channel (valid/ready, payload s_item). A write request
// appends one byte and gives no result; when the ring already holds BUFFER_DEPTH
// bytes the oldest byte is dropped. A read request drains up to read_length bytes
// (capped at MAX_READ), oldest first, one result per byte on the m_ channel, with
// last set on the final one. A read of an empty ring gives a single end-of-file
// result; a zero-length read with data held gives a single completion result.
// Write requests are taken one per cycle. A read holds s_ready low until all of its bytes
// have been issued to the memory read stage, a status-only read until its result is
// loaded there; results pass from that stage through the output register to m_. The burst
// rate is one byte per cycle while the receiver keeps up, set by the single read port of
// the log memory and its output register.
// A stalled receiver holds the result in the output register; one further byte
// waits in the memory read stage and issuing resumes once the output register is taken.
// Synchronous reset clears the read pointer and fill level; the memory contents are not
// cleared, since a read never reaches an entry that was never written.
module overwrite_oldest_log_ring_top
    import owlog_pkg::*;
#(
    parameter int BUFFER_DEPTH = 8192,
    parameter int MAX_READ     = 64
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    localparam int PTR_W  = $clog2(BUFFER_DEPTH);
    localparam int FILL_W = $clog2(BUFFER_DEPTH + 1);
    localparam int EXT_W  = FILL_W + LEVEL_W;
    localparam int CMP_W  = FILL_W + LEN_W;
    localparam logic [PTR_W-1:0]  PtrLast = PTR_W'(BUFFER_DEPTH - 1);
    localparam logic [FILL_W-1:0] DepthF  = FILL_W'(BUFFER_DEPTH);
    localparam logic [LEN_W-1:0]  MaxLen  = LEN_W'(MAX_READ);

    logic [BYTE_W-1:0] log_mem [BUFFER_DEPTH];

    state_t              state_reg, state_next;
    logic [PTR_W-1:0]    rp_reg, rp_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [LEN_W-1:0]    remain_reg, remain_next;
    status_t             stat_code_reg, stat_code_next;
    logic [LEVEL_W-1:0]  stat_level_reg, stat_level_next;
    logic                p1_valid_reg, p1_valid_next;
    status_t             p1_status_reg, p1_status_next;
    logic                p1_last_reg, p1_last_next;
    logic [LEVEL_W-1:0]  p1_level_reg, p1_level_next;
    logic [BYTE_W-1:0]   mem_q_reg;
    logic                m_valid_reg, m_valid_next;
    out_item_t           m_item_reg, m_item_next;

    logic                accept;
    logic                move_p1;
    logic                p1_free;
    logic                issue;
    logic                stat_load;
    logic                mem_we;
    logic [PTR_W-1:0]    waddr;
    logic [PTR_W:0]      wsum;
    logic [PTR_W-1:0]    rp_inc;
    logic [FILL_W-1:0]   fill_dec;
    logic [LEN_W-1:0]    len_sat;
    logic [CMP_W-1:0]    len_x, fill_x;
    logic [LEN_W-1:0]    take_len;
    logic [EXT_W-1:0]    fill_ext, fill_dec_ext;
    logic                full;

    always_comb begin
        full     = (fill_reg == DepthF);
        rp_inc   = (rp_reg == PtrLast) ? '0 : rp_reg + 1'b1;
        fill_dec = fill_reg - 1'b1;
        wsum     = {1'b0, rp_reg} + (PTR_W + 1)'(fill_reg);
        if (wsum >= (PTR_W + 1)'(BUFFER_DEPTH)) begin
            wsum = wsum - (PTR_W + 1)'(BUFFER_DEPTH);
        end
        // When full the new byte lands where the oldest one sat.
        waddr        = full ? rp_reg : wsum[PTR_W-1:0];
        len_sat      = (s_item.read_length > MaxLen) ? MaxLen : s_item.read_length;
        len_x        = {{FILL_W{1'b0}}, len_sat};
        fill_x       = {{LEN_W{1'b0}}, fill_reg};
        take_len     = (len_x < fill_x) ? len_sat : fill_x[LEN_W-1:0];
        fill_ext     = {{LEVEL_W{1'b0}}, fill_reg};
        fill_dec_ext = {{LEVEL_W{1'b0}}, fill_dec};
    end

    always_comb begin
        state_next      = state_reg;
        rp_next         = rp_reg;
        fill_next       = fill_reg;
        remain_next     = remain_reg;
        stat_code_next  = stat_code_reg;
        stat_level_next = stat_level_reg;
        s_ready         = (state_reg == ST_IDLE);
        accept          = s_valid && s_ready;
        move_p1         = p1_valid_reg && (!m_valid_reg || m_ready);
        p1_free         = !p1_valid_reg || move_p1;
        issue           = 1'b0;
        stat_load       = 1'b0;
        mem_we          = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_item.command == CMD_WRITE) begin
                        mem_we = 1'b1;
                        if (full) begin
                            rp_next = rp_inc;
                        end else begin
                            fill_next = fill_reg + 1'b1;
                        end
                    end else if (fill_reg == '0) begin
                        stat_code_next  = STATUS_EOF;
                        stat_level_next = '0;
                        state_next      = ST_STATUS;
                    end else if (len_sat == '0) begin
                        stat_code_next  = STATUS_ZERO;
                        stat_level_next = fill_ext[LEVEL_W-1:0];
                        state_next      = ST_STATUS;
                    end else begin
                        remain_next = take_len;
                        state_next  = ST_READ;
                    end
                end
            end
            ST_STATUS: begin
                if (p1_free) begin
                    stat_load  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_READ: begin
                if (p1_free) begin
                    issue       = 1'b1;
                    rp_next     = rp_inc;
                    fill_next   = fill_dec;
                    remain_next = remain_reg - 1'b1;
                    if (remain_reg == LEN_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        p1_valid_next  = p1_valid_reg;
        p1_status_next = p1_status_reg;
        p1_last_next   = p1_last_reg;
        p1_level_next  = p1_level_reg;
        if (issue) begin
            p1_valid_next  = 1'b1;
            p1_status_next = STATUS_BYTE;
            p1_last_next   = (remain_reg == LEN_W'(1));
            p1_level_next  = fill_dec_ext[LEVEL_W-1:0];
        end else if (stat_load) begin
            p1_valid_next  = 1'b1;
            p1_status_next = stat_code_reg;
            p1_last_next   = 1'b1;
            p1_level_next  = stat_level_reg;
        end else if (move_p1) begin
            p1_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (move_p1) begin
            m_valid_next         = 1'b1;
            m_item_next.out_byte = (p1_status_reg == STATUS_BYTE) ? mem_q_reg : '0;
            m_item_next.status   = p1_status_reg;
            m_item_next.last     = p1_last_reg;
            m_item_next.level    = p1_level_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // A write and a read of the same entry never fall in the same cycle, since writes
    // occur only in the idle state and reads issue only in the read state.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            log_mem[waddr] <= s_item.data_byte;
        end
        if (issue) begin
            mem_q_reg <= log_mem[rp_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rp_reg       <= '0;
            fill_reg     <= '0;
            remain_reg   <= '0;
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rp_reg       <= rp_next;
            fill_reg     <= fill_next;
            remain_reg   <= remain_next;
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        stat_code_reg  <= stat_code_next;
        stat_level_reg <= stat_level_next;
        p1_status_reg  <= p1_status_next;
        p1_last_reg    <= p1_last_next;
        p1_level_reg   <= p1_level_next;
        m_item_reg     <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= DepthF)
        else $error("fill level exceeds buffer depth");

    a_issue_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        issue |-> (fill_reg != '0))
        else $error("memory read issued from an empty ring");

    a_read_remaining: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |-> (remain_reg != '0))
        else $error("read state entered with nothing left to drain");

    a_write_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_item.command == CMD_WRITE && !full)
        |=> (fill_reg == $past(fill_reg) + 1'b1))
        else $error("write request did not raise the fill level");

    a_issue_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (issue || stat_load) |-> p1_free)
        else $error("read stage overwritten while still holding a result");
`endif

endmodule
